// ----- hdl/ogi_pkg.sv -----
// shared types, codes and constants of the occupancy grid inflation core
package ogi_pkg;

   localparam int GRID_MAX_DEF   = 128;
   localparam int RADIUS_MAX_DEF = 15;

   localparam int FUNC_W     = 2;
   localparam int IDX_W      = 14;
   localparam int VAL_W      = 8;
   localparam int COST_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [COST_W-1:0] COST_FULL = 7'd100;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOGO        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_RATIO = 2'd3;

   localparam logic [7:0] GRID_SIZE_RST   = 8'd80;
   localparam logic [3:0] OUTER_RST       = 4'd12;
   localparam logic [3:0] NOGO_RST        = 4'd5;
   localparam logic [7:0] INNER_RATIO_RST = 8'd115;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_RUN,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic                     in_range;
      logic [IDX_W-1:0]         index;
      logic signed [VAL_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              run_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0] grid_size;
      logic [3:0] outer_radius;
      logic [3:0] nogo_radius;
      logic [7:0] inner_ratio_q8;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CLR,
      ST_K_START,
      ST_K_SQRT,
      ST_K_EVAL,
      ST_K_DIV,
      ST_K_WRITE,
      ST_W_RAW,
      ST_W_CHK,
      ST_S_RD,
      ST_S_WR,
      ST_DONE
   } back_state_type;

endpackage

// ----- hdl/ogi_front.sv -----
// front end: accepts request transfers, classifies them and queues up to two commands
module ogi_front #(
   parameter int GRID_MAX = ogi_pkg::GRID_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [ogi_pkg::FUNC_W-1:0]         func,
   input  logic [ogi_pkg::IDX_W-1:0]          cell_index,
   input  logic signed [ogi_pkg::VAL_W-1:0]   cell_value,
   output logic                               full,
   output logic                               cmd_valid,
   output ogi_pkg::cmd_type                   cmd,
   input  logic                               cmd_take
);

   localparam int CELLS = GRID_MAX * GRID_MAX;

   ogi_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   ogi_pkg::cmd_type cmd_new;

   always_comb begin
      cmd_new.index    = cell_index;
      cmd_new.value    = cell_value;
      cmd_new.in_range = (32'(cell_index) < 32'(CELLS));
      case (func)
         ogi_pkg::FUNC_WRITE: cmd_new.kind = ogi_pkg::CMD_WRITE;
         ogi_pkg::FUNC_RUN:   cmd_new.kind = ogi_pkg::CMD_RUN;
         ogi_pkg::FUNC_READ:  cmd_new.kind = ogi_pkg::CMD_READ;
         default:             cmd_new.kind = ogi_pkg::CMD_NOP;
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (cmd_take) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, cmd_take})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- hdl/ogi_back.sv -----
// back end: grid memories, kernel builder and the stamping walk of a run
module ogi_back #(
   parameter int GRID_MAX   = ogi_pkg::GRID_MAX_DEF,
   parameter int RADIUS_MAX = ogi_pkg::RADIUS_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ogi_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  ogi_pkg::cmd_type cmd,
   output logic             cmd_take,
   input  logic             rsp_room,
   output logic             rsp_push,
   output ogi_pkg::rsp_type rsp_data,
   output logic             init_busy
);

   localparam int CELLS = GRID_MAX * GRID_MAX;
   localparam int AW    = $clog2(CELLS);
   localparam int GW    = $clog2(GRID_MAX + 1);
   localparam int XW    = $clog2(GRID_MAX);
   localparam int RW    = $clog2(RADIUS_MAX + 1);
   localparam int DW    = RW + 1;
   localparam int CW    = ((XW > RW) ? XW : RW) + 2;
   localparam int KSIDE = RADIUS_MAX + 1;
   localparam int KD    = KSIDE * KSIDE;
   localparam int KAW   = $clog2(KD);
   localparam int D2W   = $clog2(2 * RADIUS_MAX * RADIUS_MAX + 1);
   localparam int SW    = D2W + 16;
   localparam int QW    = SW + 1;
   localparam int RTW   = (SW + 1) / 2;
   localparam int CNW   = $clog2(RTW);
   localparam int EW0   = (RTW > RW + 8) ? RTW : RW + 8;
   localparam int EW    = ((EW0 > 12) ? EW0 : 12) + 1;
   localparam int NW    = EW + 7;
   localparam int COSTW = ogi_pkg::COST_W;

   // memories
   logic [7:0]       raw_mem  [CELLS];
   logic [COSTW-1:0] cost_mem [CELLS];
   logic [COSTW-1:0] kern_mem [KD];

   logic signed [7:0] raw_q_ff;
   logic [COSTW-1:0]  cost_q_ff;
   logic [COSTW-1:0]  kern_q_ff;

   logic             raw_we;
   logic [AW-1:0]    raw_waddr, raw_raddr;
   logic [7:0]       raw_wdata;
   logic             cost_we;
   logic [AW-1:0]    cost_waddr, cost_raddr;
   logic [COSTW-1:0] cost_wdata;
   logic             kern_we;
   logic [KAW-1:0]   kern_waddr, kern_raddr;

   ogi_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [XW-1:0]        x_ff, x_in, y_ff, y_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [RW-1:0]        ka_ff, ka_in, kb_ff, kb_in;
   logic [QW-1:0]        sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [CNW-1:0]       sq_cnt_ff, sq_cnt_in;
   logic [NW-1:0]        rem_ff, rem_in, den_ff, den_in;
   logic [COSTW-1:0]     q_ff, q_in, kval_ff, kval_in;
   logic [2:0]           dcnt_ff, dcnt_in;
   logic [AW-1:0]        waddr_ff, waddr_in;
   logic                 rd_range_ff, rd_range_in;

   logic [GW-1:0]        gs;
   logic [RW-1:0]        outer;
   logic signed [DW-1:0] outer_s;
   logic [AW-1:0]        cmd_addr, src_addr, nb_addr;
   logic signed [CW-1:0] nx, ny;
   logic                 nb_in_grid;
   logic [RW-1:0]        abs_dx, abs_dy;
   logic [D2W-1:0]       d2;
   logic [QW-1:0]        sq_sum;
   logic [EW-1:0]        d_e, nogo_q, outer_q, inner_q, den_e;
   logic                 annulus, centre;
   logic [NW-1:0]        num, den_sh;
   logic [COSTW-1:0]     q_next;
   logic                 y_last, x_last;

   always_comb begin
      gs       = (32'(cfg.grid_size) > 32'(GRID_MAX)) ? GW'(GRID_MAX) : GW'(cfg.grid_size);
      outer    = (32'(cfg.outer_radius) > 32'(RADIUS_MAX)) ? RW'(RADIUS_MAX)
                                                           : RW'(cfg.outer_radius);
      outer_s  = $signed(DW'(outer));
      cmd_addr = AW'(cmd.index);
      src_addr = AW'(x_ff) + AW'(y_ff) * AW'(gs);
      nx       = $signed(CW'(x_ff)) + CW'(dx_ff);
      ny       = $signed(CW'(y_ff)) + CW'(dy_ff);
      nb_in_grid = (nx >= 0) && (nx < $signed(CW'(gs))) &&
                   (ny >= 0) && (ny < $signed(CW'(gs)));
      nb_addr  = AW'(nx[XW-1:0]) + AW'(ny[XW-1:0]) * AW'(gs);
      abs_dx   = (dx_ff < 0) ? RW'(-dx_ff) : RW'(dx_ff);
      abs_dy   = (dy_ff < 0) ? RW'(-dy_ff) : RW'(dy_ff);
      y_last   = (GW'(y_ff) + GW'(1) >= gs);
      x_last   = (GW'(x_ff) + GW'(1) >= gs);
      // kernel evaluation terms
      d2       = D2W'(ka_ff) * D2W'(ka_ff) + D2W'(kb_ff) * D2W'(kb_ff);
      sq_sum   = sq_r_ff + sq_bit_ff;
      d_e      = EW'(sq_r_ff[RTW-1:0]);
      nogo_q   = EW'({cfg.nogo_radius, 8'b0});
      outer_q  = EW'(outer) << 8;
      inner_q  = EW'(cfg.inner_ratio_q8) * EW'(outer);
      den_e    = (EW'(outer) - EW'(cfg.nogo_radius)) << 8;
      annulus  = (inner_q <= d_e) && (d_e < outer_q);
      centre   = (ka_ff == '0) && (kb_ff == '0);
      num      = NW'(d_e - nogo_q) * NW'(100) + NW'(den_e) - NW'(1);
      den_sh   = den_ff << dcnt_ff;
      q_next   = q_ff;
      if (rem_ff >= den_sh) begin
         q_next = q_ff | (COSTW'(1) << dcnt_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      ka_in       = ka_ff;
      kb_in       = kb_ff;
      sq_v_in     = sq_v_ff;
      sq_r_in     = sq_r_ff;
      sq_bit_in   = sq_bit_ff;
      sq_cnt_in   = sq_cnt_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      q_in        = q_ff;
      dcnt_in     = dcnt_ff;
      kval_in     = kval_ff;
      waddr_in    = waddr_ff;
      rd_range_in = rd_range_ff;
      cmd_take    = 1'b0;
      rsp_push    = 1'b0;
      rsp_data    = '{cost: '0, run_done: 1'b0};
      init_busy   = 1'b0;
      raw_we      = 1'b0;
      raw_waddr   = cmd_addr;
      raw_wdata   = cmd.value;
      raw_raddr   = src_addr;
      cost_we     = 1'b0;
      cost_waddr  = clr_ff;
      cost_wdata  = '0;
      cost_raddr  = cmd_addr;
      kern_we     = 1'b0;
      kern_waddr  = KAW'(ka_ff) * KAW'(KSIDE) + KAW'(kb_ff);
      kern_raddr  = KAW'(abs_dy) * KAW'(KSIDE) + KAW'(abs_dx);
      case (state_ff)
         ogi_pkg::ST_INIT: begin
            init_busy = 1'b1;
            cost_we   = 1'b1;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ogi_pkg::ST_IDLE;
            end
         end
         ogi_pkg::ST_IDLE: begin
            if (cmd_valid && rsp_room) begin
               cmd_take = 1'b1;
               case (cmd.kind)
                  ogi_pkg::CMD_WRITE: begin
                     raw_we   = cmd.in_range;
                     rsp_push = 1'b1;
                  end
                  ogi_pkg::CMD_READ: begin
                     rd_range_in = cmd.in_range;
                     state_in    = ogi_pkg::ST_READ;
                  end
                  ogi_pkg::CMD_RUN: begin
                     clr_in   = '0;
                     state_in = ogi_pkg::ST_CLR;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         ogi_pkg::ST_READ: begin
            rsp_push      = 1'b1;
            rsp_data.cost = rd_range_ff ? cost_q_ff : '0;
            state_in      = ogi_pkg::ST_IDLE;
         end
         ogi_pkg::ST_CLR: begin
            cost_we = 1'b1;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               ka_in    = '0;
               kb_in    = '0;
               state_in = ogi_pkg::ST_K_START;
            end
         end
         ogi_pkg::ST_K_START: begin
            sq_v_in   = QW'(d2) << 16;
            sq_r_in   = '0;
            sq_bit_in = QW'(1) << (2 * (RTW - 1));
            sq_cnt_in = '0;
            state_in  = ogi_pkg::ST_K_SQRT;
         end
         ogi_pkg::ST_K_SQRT: begin
            // one root bit per cycle
            if (sq_v_ff >= sq_sum) begin
               sq_v_in = sq_v_ff - sq_sum;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff + CNW'(1);
            if (sq_cnt_ff == CNW'(RTW - 1)) begin
               state_in = ogi_pkg::ST_K_EVAL;
            end
         end
         ogi_pkg::ST_K_EVAL: begin
            state_in = ogi_pkg::ST_K_WRITE;
            if (centre) begin
               kval_in = ogi_pkg::COST_FULL;
            end else if (!annulus) begin
               kval_in = '0;
            end else if (d_e <= nogo_q) begin
               kval_in = ogi_pkg::COST_FULL;
            end else begin
               rem_in   = num;
               den_in   = NW'(den_e);
               q_in     = '0;
               dcnt_in  = 3'd6;
               state_in = ogi_pkg::ST_K_DIV;
            end
         end
         ogi_pkg::ST_K_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rem_ff >= den_sh) begin
               rem_in = rem_ff - den_sh;
            end
            q_in    = q_next;
            dcnt_in = dcnt_ff - 3'd1;
            if (dcnt_ff == 3'd0) begin
               kval_in  = ogi_pkg::COST_FULL - q_next;
               state_in = ogi_pkg::ST_K_WRITE;
            end
         end
         ogi_pkg::ST_K_WRITE: begin
            kern_we = 1'b1;
            if (kb_ff < outer) begin
               kb_in    = kb_ff + RW'(1);
               state_in = ogi_pkg::ST_K_START;
            end else if (ka_ff < outer) begin
               ka_in    = ka_ff + RW'(1);
               kb_in    = '0;
               state_in = ogi_pkg::ST_K_START;
            end else if (gs >= GW'(2)) begin
               x_in     = '0;
               y_in     = XW'(1);
               state_in = ogi_pkg::ST_W_RAW;
            end else begin
               state_in = ogi_pkg::ST_DONE;
            end
         end
         ogi_pkg::ST_W_RAW: begin
            state_in = ogi_pkg::ST_W_CHK;
         end
         ogi_pkg::ST_W_CHK: begin
            if (raw_q_ff > 8'sd0) begin
               dx_in    = -outer_s;
               dy_in    = -outer_s;
               state_in = ogi_pkg::ST_S_RD;
            end else if (!y_last) begin
               y_in     = y_ff + XW'(1);
               state_in = ogi_pkg::ST_W_RAW;
            end else if (!x_last) begin
               x_in     = x_ff + XW'(1);
               y_in     = XW'(1);
               state_in = ogi_pkg::ST_W_RAW;
            end else begin
               state_in = ogi_pkg::ST_DONE;
            end
         end
         ogi_pkg::ST_S_RD, ogi_pkg::ST_S_WR: begin
            if ((state_ff == ogi_pkg::ST_S_RD) && nb_in_grid) begin
               cost_raddr = nb_addr;
               waddr_in   = nb_addr;
               state_in   = ogi_pkg::ST_S_WR;
            end else begin
               if ((state_ff == ogi_pkg::ST_S_WR) && (kern_q_ff > cost_q_ff)) begin
                  cost_we    = 1'b1;
                  cost_waddr = waddr_ff;
                  cost_wdata = kern_q_ff;
               end
               // next kernel offset, then next source cell
               if (dx_ff < outer_s) begin
                  dx_in    = dx_ff + DW'(1);
                  state_in = ogi_pkg::ST_S_RD;
               end else if (dy_ff < outer_s) begin
                  dx_in    = -outer_s;
                  dy_in    = dy_ff + DW'(1);
                  state_in = ogi_pkg::ST_S_RD;
               end else if (!y_last) begin
                  y_in     = y_ff + XW'(1);
                  state_in = ogi_pkg::ST_W_RAW;
               end else if (!x_last) begin
                  x_in     = x_ff + XW'(1);
                  y_in     = XW'(1);
                  state_in = ogi_pkg::ST_W_RAW;
               end else begin
                  state_in = ogi_pkg::ST_DONE;
               end
            end
         end
         ogi_pkg::ST_DONE: begin
            rsp_push          = 1'b1;
            rsp_data.run_done = 1'b1;
            state_in          = ogi_pkg::ST_IDLE;
         end
         default: begin
            state_in = ogi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogi_pkg::ST_INIT;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ka_ff       <= ka_in;
      kb_ff       <= kb_in;
      sq_v_ff     <= sq_v_in;
      sq_r_ff     <= sq_r_in;
      sq_bit_ff   <= sq_bit_in;
      sq_cnt_ff   <= sq_cnt_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      dcnt_ff     <= dcnt_in;
      kval_ff     <= kval_in;
      waddr_ff    <= waddr_in;
      rd_range_ff <= rd_range_in;
   end

   always_ff @(posedge clock) begin
      if (raw_we) begin
         raw_mem[raw_waddr] <= raw_wdata;
      end
      raw_q_ff <= $signed(raw_mem[raw_raddr]);
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_waddr] <= cost_wdata;
      end
      cost_q_ff <= cost_mem[cost_raddr];
   end

   always_ff @(posedge clock) begin
      if (kern_we) begin
         kern_mem[kern_waddr] <= kval_ff;
      end
      kern_q_ff <= kern_mem[kern_raddr];
   end

endmodule

// ----- hdl/ogi_rsp_queue.sv -----
// two-entry result queue between the back end and the result ports
module ogi_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ogi_pkg::rsp_type push_data,
   output logic             room,
   input  logic             pop,
   output logic             empty,
   output ogi_pkg::rsp_type head
);

   ogi_pkg::rsp_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             take;

   assign empty = (count_ff == 2'd0);
   assign room  = (count_ff != 2'd2);
   assign head  = slot_ff[rd_ptr_ff];
   assign take  = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, take})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/occupancy_grid_inflation_core.sv -----
// top level of the occupancy grid inflation core
// Requests enter a two-entry command queue and results leave through a
// two-entry result queue, so both sides may stall independently. A raw write
// or a no-op is handled in the back end's idle state, and a cost read adds a
// state for the registered read of the cost memory. A run first clears the
// cost memory, then builds one quadrant of the kernel, (r+1)^2 offsets for
// outer radius r, each with a bit-serial square root plus the bit-serial
// divide where the linear falloff needs it (RTW is the square root's bit
// count, 13 at the default RADIUS_MAX), then walks the grid from row 1 on:
// each source cell is read and checked, and each obstacle stamps every kernel
// offset that lands in the grid. After reset a clearing pass over the whole
// cost memory runs with req_full high.
module occupancy_grid_inflation_core #(
   parameter int GRID_MAX   = ogi_pkg::GRID_MAX_DEF,
   parameter int RADIUS_MAX = ogi_pkg::RADIUS_MAX_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [ogi_pkg::FUNC_W-1:0]            req_func,
   input  logic [ogi_pkg::IDX_W-1:0]             req_cell_index,
   input  logic signed [ogi_pkg::VAL_W-1:0]      req_cell_value,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [ogi_pkg::COST_W-1:0]            rsp_cost,
   output logic                                  rsp_run_done,
   input  logic                                  csr_we,
   input  logic [ogi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ogi_pkg::CSR_DATA_W-1:0]        csr_data
);

   ogi_pkg::cfg_type cfg_ff, cfg_in;
   logic             front_full;
   logic             init_busy;
   logic             accept;
   logic             cmd_valid;
   ogi_pkg::cmd_type cmd;
   logic             cmd_take;
   logic             rsp_room;
   logic             rsp_push;
   ogi_pkg::rsp_type rsp_data;
   ogi_pkg::rsp_type rsp_head;

   assign req_full     = front_full || init_busy;
   assign accept       = req_push && !req_full;
   assign rsp_cost     = rsp_head.cost;
   assign rsp_run_done = rsp_head.run_done;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ogi_pkg::CSR_GRID_SIZE:   cfg_in.grid_size      = csr_data;
            ogi_pkg::CSR_OUTER:       cfg_in.outer_radius   = csr_data[3:0];
            ogi_pkg::CSR_NOGO:        cfg_in.nogo_radius    = csr_data[3:0];
            ogi_pkg::CSR_INNER_RATIO: cfg_in.inner_ratio_q8 = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{grid_size:      ogi_pkg::GRID_SIZE_RST,
                     outer_radius:   ogi_pkg::OUTER_RST,
                     nogo_radius:    ogi_pkg::NOGO_RST,
                     inner_ratio_q8: ogi_pkg::INNER_RATIO_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ogi_front #(
      .GRID_MAX (GRID_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .func       (req_func),
      .cell_index (req_cell_index),
      .cell_value (req_cell_value),
      .full       (front_full),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take)
   );

   ogi_back #(
      .GRID_MAX   (GRID_MAX),
      .RADIUS_MAX (RADIUS_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .init_busy (init_busy)
   );

   ogi_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .room      (rsp_room),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

endmodule

// ----- hdl/ogi_checker.sv -----
// port-level checker of the occupancy grid inflation core and its bind
module ogi_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_full,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input logic [ogi_pkg::COST_W-1:0]     rsp_cost,
   input logic                           rsp_run_done
);

   // after reset the cost memory clearing pass holds off requests
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_full && rsp_empty)
      else $error("request side open or results waiting right after reset");

   a_cost_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_cost <= ogi_pkg::COST_FULL)
      else $error("result cost above full cost");

   a_run_no_cost: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_run_done |-> rsp_cost == '0)
      else $error("run result carries a cost");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_cost) && $stable(rsp_run_done))
      else $error("waiting result changed before transfer");

endmodule

bind occupancy_grid_inflation_core ogi_checker u_ogi_checker (.*);
